[hdl/indexed_deque_assert.svh]
// Assertion macros used by the checker file of the indexed deque
`ifndef INDEXED_DEQUE_ASSERT_SVH
`define INDEXED_DEQUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define IDQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define IDQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/idq_pkg.sv]
// Shared types, sizes and codes of the indexed deque
package idq_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 64;
  localparam int POS_W = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_MAX        = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

[hdl/indexed_deque.sv]
// Top level of the indexed deque: request decode, cell chain and result register
//
//  channel   direction  handshake            payload
//  request   in         start && !busy       opcode, position, value_in
//  result    out        done (one cycle)     status, value_out, count
//
// A request other than max gives its result in the cycle after acceptance;
// the next request can be taken once done has fallen, as busy follows done.
// Max runs the running maximum down the chain of DEPTH cells, one cell per
// cycle; its result shows when the SWEEP state ends, and busy holds off requests.
// rst is synchronous and empties the queue; entries keep stale contents.
// The receiver cannot stall: each result shows for exactly one cycle.
module indexed_deque (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [2:0]                        opcode,
  input  logic [idq_pkg::POS_W-1:0]         position,
  input  logic signed [idq_pkg::DATA_W-1:0] value_in,
  output logic                              busy,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [idq_pkg::DATA_W-1:0] value_out,
  output logic [4:0]                        count
);

  localparam int DEPTH = idq_pkg::DEPTH;
  localparam int DATA_W = idq_pkg::DATA_W;
  localparam int CNT_W = idq_pkg::CNT_W;
  localparam int CMP_W = idq_pkg::CMP_W;

  typedef enum logic {
    IDLE,
    SWEEP
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         occ;
  logic [CNT_W-1:0]         occ_next;
  logic [CNT_W-1:0]         sweep_cnt;
  logic [CNT_W-1:0]         k;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         occ_ext;
  logic                     accept;
  logic                     is_empty;
  logic                     is_full;
  logic                     pos_bad;
  logic                     do_insert;
  logic                     do_remove;
  logic                     do_read;
  logic                     go_sweep;
  logic [1:0]               st_now;
  logic signed [DATA_W-1:0] sel_data;

  idq_pkg::cell_ctl_t       ctl      [DEPTH];
  logic                     cell_vld [DEPTH];
  logic signed [DATA_W-1:0] cell_data[DEPTH];
  logic signed [DATA_W-1:0] cell_max [DEPTH];
  logic signed [DATA_W-1:0] left_in  [DEPTH];
  logic signed [DATA_W-1:0] right_in [DEPTH];
  logic signed [DATA_W-1:0] max_in   [DEPTH];

  assign accept   = start && !busy;
  assign busy     = (state == SWEEP) || done;
  assign is_empty = (occ == '0);
  assign is_full  = (occ == CNT_W'(DEPTH));
  assign pos_ext  = CMP_W'(position);
  assign occ_ext  = CMP_W'(occ);
  assign pos_bad  = (pos_ext >= occ_ext);

  always_comb begin
    st_now    = idq_pkg::ST_OK;
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_read   = 1'b0;
    go_sweep  = 1'b0;
    k         = '0;
    occ_next  = occ;
    unique case (opcode)
      idq_pkg::OP_PUSH_BACK, idq_pkg::OP_PUSH_FRONT: begin
        k = (opcode == idq_pkg::OP_PUSH_BACK) ? occ : '0;
        if (is_full) begin
          st_now = idq_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_BACK: begin
        k = (opcode == idq_pkg::OP_POP_BACK) ? occ - CNT_W'(1) : '0;
        if (is_empty) begin
          st_now = idq_pkg::ST_EMPTY;
        end else begin
          do_remove = 1'b1;
        end
      end
      idq_pkg::OP_READ, idq_pkg::OP_REMOVE: begin
        k = CNT_W'(pos_ext);
        if (is_empty) begin
          st_now = idq_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          st_now = idq_pkg::ST_INDEX;
        end else if (opcode == idq_pkg::OP_READ) begin
          do_read = 1'b1;
        end else begin
          do_remove = 1'b1;
        end
      end
      idq_pkg::OP_INSERT: begin
        k = CNT_W'(pos_ext + CMP_W'(1));
        if (is_empty) begin
          st_now = idq_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          st_now = idq_pkg::ST_INDEX;
        end else if (is_full) begin
          st_now = idq_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      idq_pkg::OP_MAX: begin
        if (is_empty) begin
          st_now = idq_pkg::ST_EMPTY;
        end else begin
          go_sweep = 1'b1;
        end
      end
      default: begin
        st_now = idq_pkg::ST_OK;
      end
    endcase
    if (do_insert) begin
      occ_next = occ + CNT_W'(1);
    end else if (do_remove) begin
      occ_next = occ - CNT_W'(1);
    end
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (k == CNT_W'(i)) begin
        sel_data = sel_data | cell_data[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].load       = accept && do_insert && (CNT_W'(i) == k);
      ctl[i].take_left  = accept && do_insert && (CNT_W'(i) > k);
      ctl[i].take_right = accept && do_remove && (CNT_W'(i) >= k);
      cell_vld[i]       = (CNT_W'(i) < occ);
      left_in[i]        = (i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1];
      right_in[i]       = (i == DEPTH - 1) ? '0 : cell_data[(i == DEPTH - 1) ? i : i + 1];
      max_in[i]         = (i == 0) ? {1'b1, {(DATA_W - 1){1'b0}}}
                                   : cell_max[(i == 0) ? 0 : i - 1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    idq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .valid    (cell_vld[g]),
      .left     (left_in[g]),
      .right    (right_in[g]),
      .value_in (value_in),
      .max_in   (max_in[g]),
      .data     (cell_data[g]),
      .max_out  (cell_max[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      occ       <= '0;
      done      <= 1'b0;
      sweep_cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            occ       <= occ_next;
            status    <= st_now;
            value_out <= (do_read || do_remove) ? sel_data : '0;
            count     <= 5'(occ_next);
            sweep_cnt <= '0;
            if (go_sweep) begin
              state <= SWEEP;
            end else begin
              done <= 1'b1;
            end
          end
        end
        SWEEP: begin
          if (sweep_cnt == CNT_W'(DEPTH)) begin
            value_out <= cell_max[DEPTH-1];
            done      <= 1'b1;
            state     <= IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/idq_cell.sv]
// One storage cell of the deque chain with its stage of the running maximum
module idq_cell (
  input  logic                              clk,
  input  idq_pkg::cell_ctl_t                ctl,
  input  logic                              valid,
  input  logic signed [idq_pkg::DATA_W-1:0] left,
  input  logic signed [idq_pkg::DATA_W-1:0] right,
  input  logic signed [idq_pkg::DATA_W-1:0] value_in,
  input  logic signed [idq_pkg::DATA_W-1:0] max_in,
  output logic signed [idq_pkg::DATA_W-1:0] data,
  output logic signed [idq_pkg::DATA_W-1:0] max_out
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= value_in;
    end else if (ctl.take_left) begin
      data <= left;
    end else if (ctl.take_right) begin
      data <= right;
    end
    max_out <= (valid && (data > max_in)) ? data : max_in;
  end

endmodule

[hdl/idq_checker.sv]
// Port-level checks of the indexed deque and their binding to the top level
`include "indexed_deque_assert.svh"

module idq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic [2:0]                        opcode,
  input logic                              busy,
  input logic                              done,
  input logic [1:0]                        status,
  input logic signed [idq_pkg::DATA_W-1:0] value_out,
  input logic [4:0]                        count
);

  `IDQ_ASSERT_NXT(a_quick_done, start && !busy && (opcode != idq_pkg::OP_MAX), done)
  `IDQ_ASSERT_IMP(a_fail_zero, done && (status != idq_pkg::ST_OK), value_out == '0)
  `IDQ_ASSERT_IMP(a_count_range, done, count <= 5'(idq_pkg::DEPTH))
  `IDQ_ASSERT_NXT(a_single_strobe, done, !done)

endmodule

bind indexed_deque idq_checker u_idq_checker (.*);
